[hw/rtl/assert_macros.svh]
// Assertion macros shared by the button click classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define BCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bcc_pkg.sv]
// Types, constants and register map of the button click classifier.
package bcc_pkg;

  localparam int unsigned NUM_KEYS_DEF   = 4;
  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned LEVEL_BITS     = 4;
  localparam int unsigned CODE_W         = 4;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned REPEAT_W       = 5;
  localparam int unsigned PADDR_W        = 4;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [CNT_W-1:0] LONG_HOLD_RST = 8'd100;
  localparam logic [CNT_W-1:0] WINDOW_RST    = 8'd30;

  // Register indexes (byte address / 4)
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LONG_HOLD = 2'd0;
  localparam reg_idx_t REG_WINDOW    = 2'd1;
  localparam reg_idx_t REG_REPEAT_EN = 2'd2;

  // Input actions
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Code kinds added to key*3
  localparam int unsigned KIND_SINGLE = 1;
  localparam int unsigned KIND_DOUBLE = 2;
  localparam int unsigned KIND_LONG   = 3;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2,
    PH_LONG     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef struct packed {
    logic [CNT_W-1:0] long_hold;
    logic [CNT_W-1:0] window;
    logic             repeat_en;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } code_t;

endpackage

[hw/rtl/button_click_event_classifier_core.sv]
// Top level of the button click classifier: lanes, merge stage, ring and registers.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   in      | to core   | in_valid_i / in_stall_o   | action_i, key_levels_i
//   out     | from core | out_valid_o / out_stall_i | click_code_o
//   cfg     | to core   | psel, penable, pready     | paddr, pwdata, prdata
//
// On a pop the ring is read at the transfer and the code sits in the output
// register on the next cycle. A scan tick updates all key lanes at once; the
// merge stage then pushes each code the tick raises into the ring in turn,
// lowest key first, since the ring has a single write port.
// in_stall_o stays high while codes drain and while a taken pop result waits
// under out_stall_i. Reset clears all lane state and both ring pointers.
`include "assert_macros.svh"

module button_click_event_classifier_core #(
  parameter int unsigned NUM_KEYS   = bcc_pkg::NUM_KEYS_DEF,
  parameter int unsigned RING_DEPTH = bcc_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [bcc_pkg::LEVEL_BITS-1:0] key_levels_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bcc_pkg::CODE_W-1:0]   click_code_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcc_pkg::PDATA_W-1:0]  pwdata,
  output logic [bcc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [bcc_pkg::CNT_W-1:0] long_hold_q;
  logic [bcc_pkg::CNT_W-1:0] window_q;
  logic                      repeat_en_q;
  bcc_pkg::cfg_t             cfg;
  bcc_pkg::reg_idx_t         reg_idx;
  logic                      cfg_wr;

  logic           in_xfer;
  logic           tick;
  logic           pop;
  logic           merge_busy;
  logic           pop_ready;
  bcc_pkg::code_t lane_codes [NUM_KEYS];
  bcc_pkg::code_t push;
  logic           any_code;

  // ---------------------------------------------------------------------
  // Configuration registers: write on the access phase, read back at once
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q <= bcc_pkg::LONG_HOLD_RST;
      window_q    <= bcc_pkg::WINDOW_RST;
      repeat_en_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bcc_pkg::REG_LONG_HOLD: long_hold_q <= pwdata[bcc_pkg::CNT_W-1:0];
        bcc_pkg::REG_WINDOW:    window_q    <= pwdata[bcc_pkg::CNT_W-1:0];
        bcc_pkg::REG_REPEAT_EN: repeat_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bcc_pkg::REG_LONG_HOLD: prdata = bcc_pkg::PDATA_W'(long_hold_q);
      bcc_pkg::REG_WINDOW:    prdata = bcc_pkg::PDATA_W'(window_q);
      bcc_pkg::REG_REPEAT_EN: prdata = bcc_pkg::PDATA_W'(repeat_en_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg = '{long_hold: long_hold_q, window: window_q, repeat_en: repeat_en_q};

  // ---------------------------------------------------------------------
  // Input transfer: hold off while codes drain or a result is stuck
  // ---------------------------------------------------------------------
  assign in_stall_o = merge_busy || !pop_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign tick       = in_xfer && (action_i == bcc_pkg::ACT_SCAN);
  assign pop        = in_xfer && (action_i == bcc_pkg::ACT_POP);

  // ---------------------------------------------------------------------
  // Key lanes: one per key, all advanced by the same scan tick
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic released;
    if (k < bcc_pkg::LEVEL_BITS) begin : g_pin
      assign released = key_levels_i[k];
    end else begin : g_nopin
      // keys without a pin read as released
      assign released = 1'b1;
    end

    bcc_lane #(
      .KEY_INDEX (k)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tick_i     (tick),
      .released_i (released),
      .cfg_i      (cfg),
      .code_o     (lane_codes[k])
    );
  end

  always_comb begin
    any_code = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) any_code = any_code | lane_codes[k].valid;
  end

  // ---------------------------------------------------------------------
  // Merge stage: push the tick's codes into the ring, lowest key first
  // ---------------------------------------------------------------------
  bcc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (tick),
    .lanes_i (lane_codes),
    .busy_o  (merge_busy),
    .push_o  (push)
  );

  // ---------------------------------------------------------------------
  // Code ring and output register
  // ---------------------------------------------------------------------
  bcc_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .pop_ready_o  (pop_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .click_code_o (click_code_o)
  );

  `BCC_ASSERT(a_no_xfer_while_drain, clk_i, rst_ni, !(in_xfer && push.valid), "input taken while codes drain")
  `BCC_ASSERT_NEXT(a_codes_start_drain, clk_i, rst_ni, tick && any_code, merge_busy, "tick codes were not queued")

endmodule

[hw/rtl/bcc_lane.sv]
// One key lane: debounce, hold timing and click classification.
module bcc_lane #(
  parameter int unsigned KEY_INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic             released_i,
  input  bcc_pkg::cfg_t    cfg_i,
  output bcc_pkg::code_t   code_o
);

  localparam logic [bcc_pkg::CODE_W-1:0] CodeSingle =
    bcc_pkg::CODE_W'((KEY_INDEX * 3 + bcc_pkg::KIND_SINGLE) % 16);
  localparam logic [bcc_pkg::CODE_W-1:0] CodeDouble =
    bcc_pkg::CODE_W'((KEY_INDEX * 3 + bcc_pkg::KIND_DOUBLE) % 16);
  localparam logic [bcc_pkg::CODE_W-1:0] CodeLong =
    bcc_pkg::CODE_W'((KEY_INDEX * 3 + bcc_pkg::KIND_LONG) % 16);

  bcc_pkg::phase_e               phase_q, phase_d;
  logic [bcc_pkg::CNT_W-1:0]     hold_q, hold_d;
  logic [bcc_pkg::REPEAT_W-1:0]  rep_q, rep_d, rep_inc;
  logic                          wait_q, wait_d;
  logic [bcc_pkg::CNT_W-1:0]     win_q, win_d, win_inc;
  bcc_pkg::event_e               ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcc_pkg::PH_IDLE;
      hold_q  <= '0;
      rep_q   <= '0;
      wait_q  <= 1'b0;
      win_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      rep_q   <= rep_d;
      wait_q  <= wait_d;
      win_q   <= win_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    rep_d   = rep_q;
    wait_d  = wait_q;
    win_d   = win_q;
    rep_inc = rep_q + 5'd1;
    win_inc = win_q + 8'd1;
    ev      = bcc_pkg::EV_NONE;
    code_o  = '0;
    if (tick_i) begin
      unique case (phase_q)
        bcc_pkg::PH_IDLE: begin
          if (!released_i) phase_d = bcc_pkg::PH_DEBOUNCE;
        end
        bcc_pkg::PH_DEBOUNCE: begin
          if (!released_i) begin
            hold_d  = '0;
            phase_d = bcc_pkg::PH_HOLD;
          end else begin
            phase_d = bcc_pkg::PH_IDLE;
          end
        end
        bcc_pkg::PH_HOLD: begin
          if (released_i) begin
            ev      = bcc_pkg::EV_SHORT;
            phase_d = bcc_pkg::PH_IDLE;
          end else begin
            hold_d = hold_q + 8'd1;
            if (hold_d >= cfg_i.long_hold) begin
              ev      = bcc_pkg::EV_LONG;
              phase_d = bcc_pkg::PH_LONG;
            end
          end
        end
        bcc_pkg::PH_LONG: begin
          if (released_i) begin
            phase_d = bcc_pkg::PH_IDLE;
          end else if (cfg_i.repeat_en) begin
            // repeat counter keeps its value across holds
            if (rep_inc[bcc_pkg::REPEAT_W-1]) begin
              rep_d = '0;
              ev    = bcc_pkg::EV_LONG;
            end else begin
              rep_d = rep_inc;
            end
          end
        end
        default: phase_d = bcc_pkg::PH_IDLE;
      endcase

      if (!wait_q) begin
        if (ev == bcc_pkg::EV_SHORT) begin
          win_d  = '0;
          wait_d = 1'b1;
        end else if (ev == bcc_pkg::EV_LONG) begin
          code_o = '{valid: 1'b1, code: CodeLong};
        end
      end else if (ev == bcc_pkg::EV_SHORT) begin
        code_o = '{valid: 1'b1, code: CodeDouble};
        wait_d = 1'b0;
      end else begin
        // a long inside the window is dropped; the window keeps running
        win_d = win_inc;
        if (win_inc >= cfg_i.window) begin
          code_o = '{valid: 1'b1, code: CodeSingle};
          wait_d = 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/bcc_merge.sv]
// Merge stage: hold the codes of one tick and push them in key order.
`include "assert_macros.svh"

module bcc_merge #(
  parameter int unsigned NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  bcc_pkg::code_t lanes_i [NUM_KEYS],
  output logic           busy_o,
  output bcc_pkg::code_t push_o
);

  localparam int unsigned KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0]       pending_q, pending_d;
  logic [bcc_pkg::CODE_W-1:0] codes_q [NUM_KEYS];
  logic [KeyW-1:0]           sel;

  always_comb begin
    sel = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (pending_q[k]) sel = KeyW'(k);
    end
  end

  assign busy_o      = |pending_q;
  assign push_o.valid = busy_o;
  assign push_o.code  = codes_q[sel];

  always_comb begin
    pending_d = pending_q;
    if (load_i) begin
      for (int k = 0; k < NUM_KEYS; k++) pending_d[k] = lanes_i[k].valid;
    end else if (busy_o) begin
      pending_d = pending_q & ~(NUM_KEYS'(1) << sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < NUM_KEYS; k++) codes_q[k] <= lanes_i[k].code;
    end
  end

  `BCC_ASSERT(a_load_when_idle, clk_i, rst_ni, !(load_i && busy_o), "tick loaded while draining")
  `BCC_ASSERT_NEXT(a_drain_one, clk_i, rst_ni, busy_o, $countones(pending_q) == $countones($past(pending_q)) - 1, "drain did not retire one code")

endmodule

[hw/rtl/bcc_ring.sv]
// Code ring with registered read and the output register.
`include "assert_macros.svh"

module bcc_ring #(
  parameter int unsigned RING_DEPTH = bcc_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcc_pkg::code_t             push_i,
  input  logic                       pop_i,
  output logic                       pop_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bcc_pkg::CODE_W-1:0] click_code_o
);

  localparam int unsigned AddrW = $clog2(RING_DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(RING_DEPTH - 1);

  logic [bcc_pkg::CODE_W-1:0] mem [RING_DEPTH];
  logic [AddrW-1:0]           head_q, tail_q;
  logic [bcc_pkg::CODE_W-1:0] rd_q;
  logic                       empty_q;
  logic                       out_valid_q;
  logic                       empty;

  assign empty        = (head_q == tail_q);
  assign pop_ready_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign click_code_o = empty_q ? '0 : rd_q;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem[tail_q] <= push_i.code;
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rd_q    <= mem[head_q];
      empty_q <= empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // no full check: an overrun simply laps the head
      if (push_i.valid) tail_q <= (tail_q == LastAddr) ? '0 : tail_q + 1'b1;
      if (pop_i && !empty) head_q <= (head_q == LastAddr) ? '0 : head_q + 1'b1;
      if (pop_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `BCC_ASSERT(a_no_push_on_pop, clk_i, rst_ni, !(push_i.valid && pop_i), "push and pop in one cycle")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the button click classifier core.
module tb_top;
  import bcc_pkg::*;

  localparam int NK            = NUM_KEYS_DEF;
  localparam int RING          = RING_DEPTH_DEF;
  // A repeated long comes once the repeat counter passes this value.
  localparam int REPEAT_LIMIT  = 15;
  // A scan tick may keep the core busy while the merge stage pushes its codes.
  localparam int DRAIN_CYCLES  = 2 * (1 + NK) + 2;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLDOFF_LEN   = 400;

  // Clock, reset and the ports of the core.
  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [LEVEL_BITS-1:0] key_levels_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CODE_W-1:0]     click_code_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // Codes that pops have been accepted for, oldest first.
  logic [CODE_W-1:0] pending_codes[$];
  int                fail_count;

  // Idling switches for each side, and the long receiver hold-off request.
  bit tx_idle_on;
  bit rx_idle_on;
  int holdoff_len;

  // Shadow copy of the registers, the per-key state and the ring of the core.
  cfg_t              cfg_m;
  phase_e            phase_m[NK];
  logic [CNT_W-1:0]  hold_m[NK];
  logic [REPEAT_W-1:0] rpt_m[NK];
  logic              wait_m[NK];
  logic [CNT_W-1:0]  win_m[NK];
  logic [CODE_W-1:0] ring_m[RING];
  int                head_m;
  int                tail_m;

  // Press pattern generator state: current level and ticks left in it.
  bit gen_low[NK];
  int gen_left[NK];

  button_click_event_classifier_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .click_code_o (click_code_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Behavioural model of the classifier
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    cfg_m.long_hold = LONG_HOLD_RST;
    cfg_m.window    = WINDOW_RST;
    cfg_m.repeat_en = 1'b0;
    for (int k = 0; k < NK; k++) begin
      phase_m[k] = PH_IDLE;
      hold_m[k]  = '0;
      rpt_m[k]   = '0;
      wait_m[k]  = 1'b0;
      win_m[k]   = '0;
    end
    for (int i = 0; i < RING; i++) ring_m[i] = '0;
    head_m = 0;
    tail_m = 0;
  endfunction

  // Debounce and hold tracking of one key for one tick; return its event.
  function automatic event_e track_key(int k, logic released);
    event_e ev = EV_NONE;
    case (phase_m[k])
      PH_IDLE: begin
        if (!released) phase_m[k] = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (!released) begin
          hold_m[k]  = '0;
          phase_m[k] = PH_HOLD;
        end else begin
          phase_m[k] = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (released) begin
          ev         = EV_SHORT;
          phase_m[k] = PH_IDLE;
        end else begin
          hold_m[k] = hold_m[k] + 1'b1;
          if (hold_m[k] >= cfg_m.long_hold) begin
            ev         = EV_LONG;
            phase_m[k] = PH_LONG;
          end
        end
      end
      default: begin
        // The repeat counter carries over from earlier holds on purpose.
        if (released) begin
          phase_m[k] = PH_IDLE;
        end else if (cfg_m.repeat_en) begin
          rpt_m[k] = rpt_m[k] + 1'b1;
          if (rpt_m[k] > REPEAT_LIMIT) begin
            rpt_m[k] = '0;
            ev       = EV_LONG;
          end
        end
      end
    endcase
    return ev;
  endfunction

  // Push without a full check: a wrap makes the ring look empty again.
  function automatic void store_code(int k, int unsigned kind);
    logic [CODE_W-1:0] code;
    code           = CODE_W'(3 * k + kind);
    ring_m[tail_m] = code;
    tail_m         = (tail_m + 1) % RING;
  endfunction

  // Turn press events into single, double and long codes.
  function automatic void sort_click(int k, event_e ev);
    if (!wait_m[k]) begin
      if (ev == EV_SHORT) begin
        win_m[k]  = '0;
        wait_m[k] = 1'b1;
      end else if (ev == EV_LONG) begin
        store_code(k, KIND_LONG);
      end
    end else if (ev == EV_SHORT) begin
      store_code(k, KIND_DOUBLE);
      wait_m[k] = 1'b0;
    end else begin
      // A long inside the window is dropped; the window keeps running.
      win_m[k] = win_m[k] + 1'b1;
      if (win_m[k] >= cfg_m.window) begin
        store_code(k, KIND_SINGLE);
        wait_m[k] = 1'b0;
      end
    end
  endfunction

  function automatic void scan_keys(logic [LEVEL_BITS-1:0] levels);
    logic released;
    for (int k = 0; k < NK; k++) begin
      released = (k < LEVEL_BITS) ? levels[k] : 1'b1;
      sort_click(k, track_key(k, released));
    end
  endfunction

  // Pop the oldest code, or zero from an empty ring.
  function automatic logic [CODE_W-1:0] take_code();
    logic [CODE_W-1:0] code;
    if (head_m == tail_m) return '0;
    code   = ring_m[head_m];
    head_m = (head_m + 1) % RING;
    return code;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then advance the model.
  task automatic send_item(logic act, logic [LEVEL_BITS-1:0] levels);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_levels_i <= levels;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (act == ACT_POP) pending_codes.push_back(take_code());
    else scan_keys(levels);
  endtask

  // Drop valid, wait for every pop result, then let queued codes settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, access cycle, done once pready is seen.
  task automatic write_reg(reg_idx_t idx, logic [CNT_W-1:0] val);
    logic [PDATA_W-1:0] noise;
    noise   = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Fill the unused upper bits with junk; the register keeps only its width.
    pwdata  <= {noise[PDATA_W-1:CNT_W], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LONG_HOLD: cfg_m.long_hold = val;
      REG_WINDOW:    cfg_m.window    = val;
      REG_REPEAT_EN: cfg_m.repeat_en = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(int long_hold, int window, bit repeat_en);
    wait_idle();
    write_reg(REG_LONG_HOLD, CNT_W'(long_hold));
    write_reg(REG_WINDOW, CNT_W'(window));
    write_reg(REG_REPEAT_EN, CNT_W'(repeat_en));
  endtask

  // Pick how long a key stays in its new level, scaled to the thresholds.
  function automatic int pick_span(bit pressed);
    int lh;
    int win;
    int sel;
    lh  = int'(cfg_m.long_hold);
    win = int'(cfg_m.window);
    sel = $urandom_range(0, 9);
    if (pressed) begin
      if (sel == 0) return 1;                                  // bounce
      if (sel <= 4) return $urandom_range(2, lh + 2);          // short or just long
      if (sel <= 7) return $urandom_range(lh + 2, lh + 12);    // plain long
      return $urandom_range(lh + 14, lh + 60);                 // long with repeats
    end
    if (sel <= 6) return $urandom_range(1, win + 1);           // quick second press
    return $urandom_range(win + 1, win + 8);                   // window runs out
  endfunction

  // Mostly press patterns with random timing, some noise, and pops mixed in.
  task automatic random_traffic(int n_items, int pop_pct);
    logic [LEVEL_BITS-1:0] levels;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(1, 100) <= pop_pct) begin
        send_item(ACT_POP, LEVEL_BITS'($urandom_range(0, (1 << LEVEL_BITS) - 1)));
      end else if ($urandom_range(0, 15) == 0) begin
        send_item(ACT_SCAN, LEVEL_BITS'($urandom_range(0, (1 << LEVEL_BITS) - 1)));
      end else begin
        levels = '1;
        for (int k = 0; k < NK && k < LEVEL_BITS; k++) begin
          if (gen_left[k] == 0) begin
            gen_low[k]  = !gen_low[k];
            gen_left[k] = pick_span(gen_low[k]);
          end
          levels[k]   = !gen_low[k];
          gen_left[k] = gen_left[k] - 1;
        end
        send_item(ACT_SCAN, levels);
      end
    end
  endtask

  // Compare every result transfer with the oldest expected code.
  always @(posedge clk_i) begin
    logic [CODE_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("click code %0d arrived with nothing expected", click_code_o);
      end else begin
        want = pending_codes.pop_front();
        if (click_code_o !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("click code mismatch: expected %0d, got %0d", want, click_code_o);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off counted here.
  initial begin
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (holdoff_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (holdoff_len) @(posedge clk_i);
        holdoff_len = 0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-made sequences: empty pop, bounce, single, double, long in the
  // window, all keys long together, extreme level patterns.
  task automatic test_directed();
    set_config(1, 6, 1'b1);
    send_item(ACT_POP, 4'b0000);           // empty ring gives zero
    send_item(ACT_SCAN, 4'b1110);          // key 0 low for one tick only
    send_item(ACT_SCAN, 4'b1111);
    repeat (2) send_item(ACT_SCAN, 4'b1101);
    send_item(ACT_SCAN, 4'b1111);          // key 1 short, window opens
    repeat (2) send_item(ACT_SCAN, 4'b1011);
    send_item(ACT_SCAN, 4'b1111);          // key 2 first short
    repeat (2) send_item(ACT_SCAN, 4'b1011);
    send_item(ACT_SCAN, 4'b1111);          // key 2 second short: double
    repeat (2) send_item(ACT_SCAN, 4'b1110);
    send_item(ACT_SCAN, 4'b1111);          // key 0 short
    repeat (3) send_item(ACT_SCAN, 4'b1110); // long inside the window, dropped
    repeat (3) send_item(ACT_SCAN, 4'b0000); // every key held at once
    send_item(ACT_SCAN, 4'b1111);
    repeat (5) send_item(ACT_POP, 4'b1111);
  endtask

  // Zero thresholds: long on the first held tick, window of one tick.
  task automatic test_zero_thresholds();
    set_config(0, 0, 1'b1);
    random_traffic(40, 25);
  endtask

  // Push more codes than the ring holds without popping, then drain it.
  task automatic test_ring_overflow();
    set_config(1, 1, 1'b0);
    repeat (5) begin
      repeat (3) send_item(ACT_SCAN, 4'b0000);
      send_item(ACT_SCAN, 4'b1111);
    end
    repeat (6) send_item(ACT_POP, LEVEL_BITS'($urandom_range(0, 15)));
    repeat (3) send_item(ACT_SCAN, 4'b0101);
    send_item(ACT_SCAN, 4'b1111);
    repeat (4) send_item(ACT_POP, LEVEL_BITS'($urandom_range(0, 15)));
  endtask

  // Hold the receiver off for a long stretch so the core stalls its input.
  task automatic test_input_backpressure();
    set_config(4, 6, 1'b1);
    holdoff_len = HOLDOFF_LEN;
    random_traffic(60, 50);
  endtask

  // Random press traffic across several settings, extremes included;
  // the last phase runs with no idling on either side.
  task automatic test_random_settings();
    set_config(255, 255, 1'b1);
    random_traffic(350, 20);
    set_config(1, 1, 1'b1);
    random_traffic(120, 25);
    set_config(int'(LONG_HOLD_RST), int'(WINDOW_RST), 1'b0);
    random_traffic(150, 25);
    set_config(7, 12, 1'b0);
    random_traffic(120, 25);
    set_config(5, 3, 1'b1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(120, 25);
  endtask

  initial begin
    // Drive every input to a known value and hold reset.
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_SCAN;
    key_levels_i <= '1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    fail_count   = 0;
    holdoff_len  = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_zero_thresholds();
    test_ring_overflow();
    test_input_backpressure();
    test_random_settings();

    wait_idle();
    if (fail_count == 0 && pending_codes.size() == 0) begin
      $display("PASS button_click_event_classifier_core");
    end else begin
      $display("FAIL button_click_event_classifier_core");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #4000000;
    $display("FAIL button_click_event_classifier_core");
    $finish;
  end

endmodule
